@@ hdl/sliding_window_latency_stats_unit_defines.svh @@
// assertion macros for the sliding window latency statistics unit
`ifndef SLIDING_WINDOW_LATENCY_STATS_UNIT_DEFINES_SVH
`define SLIDING_WINDOW_LATENCY_STATS_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define SWLSS_ASSERT_HOLDS(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("swlss check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define SWLSS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("swlss check failed");

`endif

@@ hdl/swlss_pkg.sv @@
// shared types, constants and helpers of the sliding window latency statistics unit
package swlss_pkg;

	localparam int WINDOW_MAX = 64;
	localparam int IDX_W      = $clog2(WINDOW_MAX);
	localparam int LEN_W      = $clog2(WINDOW_MAX + 1);
	localparam int SMP_W      = 24;
	localparam int SUM_W      = 30;
	localparam int DIV_CNT_W  = $clog2(SUM_W);
	localparam int GRP        = 8;
	localparam int NGRP       = WINDOW_MAX / GRP;
	localparam int GCNT_W     = $clog2(GRP + 1);
	localparam int CFG_IDX_W  = 1;

	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [LEN_W-1:0]     cnt_t;
	typedef logic [SMP_W-1:0]     smp_t;
	typedef logic [SUM_W-1:0]     sum_t;
	typedef logic [GCNT_W-1:0]    gcnt_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_WINDOW_LENGTH = 1'b0;
	localparam cfg_idx_t REG_BUDGET        = 1'b1;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_CLEAR,
		OP_DELETE,
		OP_INSERT
	} cell_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVICT,
		ST_INSERT,
		ST_GATHER,
		ST_WAIT
	} state_t;

	// broadcast to every cell of the sorted row
	typedef struct packed {
		cell_op_t op;
		smp_t     sample;
		smp_t     evict;
		idx_t     oldest;
		smp_t     budget;
	} cell_cmd_t;

	// what a cell shows its neighbors
	typedef struct packed {
		logic vld;
		smp_t val;
		idx_t age;
		logic ins_hit;
	} cell_link_t;

	localparam cell_link_t LINK_EDGE = '0;

	// zero-based position of rank ceil(19n/20); x/20 as x*3277>>16, exact for x < 1300
	function automatic idx_t p95_index(cnt_t n);
		logic [10:0] num;
		logic [22:0] prod;
		logic [6:0]  rank;
		num  = 11'(n) * 11'd19 + 11'd19;
		prod = 23'(num) * 23'd3277;
		rank = prod[22:16];
		return idx_t'(rank - 7'd1);
	endfunction

endpackage

@@ hdl/swlss_cell.sv @@
// one cell of the sorted sample row: value, age and valid, with neighbor shifts
module swlss_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  swlss_pkg::cell_cmd_t  cmd,
	input  swlss_pkg::cell_link_t left,
	input  swlss_pkg::cell_link_t right,
	output swlss_pkg::cell_link_t link,
	output logic                  over
);

	logic            vld_q;
	swlss_pkg::smp_t val_q;
	swlss_pkg::idx_t age_q;
	logic            del_hit;
	logic            ins_hit;

	// equal values keep the youngest first, so the evicted one is last of its run
	assign del_hit = vld_q && ((val_q > cmd.evict) || (age_q == cmd.oldest));
	assign ins_hit = !vld_q || (val_q >= cmd.sample);

	assign link.vld     = vld_q;
	assign link.val     = val_q;
	assign link.age     = age_q;
	assign link.ins_hit = ins_hit;
	assign over         = vld_q && (val_q > cmd.budget);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			unique case (cmd.op)
				swlss_pkg::OP_CLEAR: begin
					vld_q <= 1'b0;
				end
				swlss_pkg::OP_DELETE: begin
					if (del_hit) begin
						vld_q <= right.vld;
					end
				end
				swlss_pkg::OP_INSERT: begin
					if (ins_hit) begin
						vld_q <= left.ins_hit ? left.vld : 1'b1;
					end
				end
				swlss_pkg::OP_NONE: begin
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			swlss_pkg::OP_DELETE: begin
				if (del_hit) begin
					val_q <= right.val;
					age_q <= right.age;
				end
			end
			swlss_pkg::OP_INSERT: begin
				if (!ins_hit) begin
					age_q <= age_q + swlss_pkg::idx_t'(1);
				end else if (left.ins_hit) begin
					val_q <= left.val;
					age_q <= left.age + swlss_pkg::idx_t'(1);
				end else begin
					val_q <= cmd.sample;
					age_q <= '0;
				end
			end
			swlss_pkg::OP_CLEAR, swlss_pkg::OP_NONE: begin
			end
			default: begin
			end
		endcase
	end

endmodule

@@ hdl/swlss_div.sv @@
// restoring divider, one quotient bit per cycle, for the window mean
module swlss_div (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  swlss_pkg::sum_t dividend,
	input  swlss_pkg::cnt_t divisor,
	output logic            busy,
	output swlss_pkg::smp_t quotient
);

	logic                              busy_q;
	logic [swlss_pkg::DIV_CNT_W-1:0]   step_q;
	swlss_pkg::sum_t                   dvd_q;
	swlss_pkg::cnt_t                   dsr_q;
	swlss_pkg::cnt_t                   rem_q;
	swlss_pkg::smp_t                   quo_q;
	logic [swlss_pkg::LEN_W:0]         trial;
	logic                              fits;

	assign trial    = {rem_q, dvd_q[swlss_pkg::SUM_W-1]};
	assign fits     = trial >= {1'b0, dsr_q};
	assign busy     = busy_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= swlss_pkg::DIV_CNT_W'(swlss_pkg::SUM_W - 1);
		end else if (busy_q) begin
			step_q <= step_q - swlss_pkg::DIV_CNT_W'(1);
			if (step_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[swlss_pkg::SUM_W-2:0], 1'b0};
			// quotient never exceeds the largest sample, so the top bits shifted out are zero
			quo_q <= {quo_q[swlss_pkg::SMP_W-2:0], fits};
			if (fits) begin
				rem_q <= swlss_pkg::LEN_W'(trial - {1'b0, dsr_q});
			end else begin
				rem_q <= trial[swlss_pkg::LEN_W-1:0];
			end
		end
	end

endmodule

@@ hdl/sliding_window_latency_stats_unit.sv @@
// top level: sample ring, sorted cell row, mean divider and result register
//
//  channel | valid         | stall         | payload
//  --------+---------------+---------------+-----------------------------------------------
//  sample  | sample_valid  | sample_stall  | sample_us
//  result  | result_valid  | result_stall  | sample_count average_us maximum_us p95_us
//          |               |               | over_budget_count
//  config  | cfg_wr        | (none)        | cfg_idx cfg_wdata
//
// after transfer a sample passes the states evict, which takes the oldest sample out of the
// cell row when the window is full, insert, which puts the new one in and starts the mean
// divider, gather and wait, while the divider runs and the row goes through two registered
// reduction stages; then the result register is loaded. the next sample is taken the cycle
// after that load; a stalled result holds there while the following sample is worked on.
// reset empties the window and the cell row at once; the ring needs no clearing pass.
`include "sliding_window_latency_stats_unit_defines.svh"

module sliding_window_latency_stats_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr,
	input  swlss_pkg::cfg_idx_t       cfg_idx,
	input  logic [swlss_pkg::SMP_W-1:0] cfg_wdata,
	input  logic                      sample_valid,
	output logic                      sample_stall,
	input  logic [swlss_pkg::SMP_W-1:0] sample_us,
	output logic                      result_valid,
	input  logic                      result_stall,
	output logic [swlss_pkg::LEN_W-1:0] sample_count,
	output logic [swlss_pkg::SMP_W-1:0] average_us,
	output logic [swlss_pkg::SMP_W-1:0] maximum_us,
	output logic [swlss_pkg::SMP_W-1:0] p95_us,
	output logic [swlss_pkg::LEN_W-1:0] over_budget_count
);

	swlss_pkg::state_t     state_q;
	swlss_pkg::state_t     state_d;
	swlss_pkg::cnt_t       wl_q;
	swlss_pkg::smp_t       bud_q;
	swlss_pkg::cnt_t       cnt_q;
	swlss_pkg::idx_t       wp_q;
	swlss_pkg::sum_t       sum_q;
	swlss_pkg::smp_t       smp_q;
	swlss_pkg::smp_t       rd_q;
	swlss_pkg::smp_t       ring_q [swlss_pkg::WINDOW_MAX];
	swlss_pkg::idx_t       rank_q;
	logic                  out_vld_q;
	swlss_pkg::cnt_t       cnt_out_q;
	swlss_pkg::smp_t       avg_out_q;
	swlss_pkg::smp_t       max_out_q;
	swlss_pkg::smp_t       p95_out_q;
	swlss_pkg::cnt_t       ovr_out_q;

	swlss_pkg::smp_t       p95_grp_s1 [swlss_pkg::NGRP];
	swlss_pkg::smp_t       max_grp_s1 [swlss_pkg::NGRP];
	swlss_pkg::gcnt_t      ovr_grp_s1 [swlss_pkg::NGRP];
	swlss_pkg::smp_t       p95_grp    [swlss_pkg::NGRP];
	swlss_pkg::smp_t       max_grp    [swlss_pkg::NGRP];
	swlss_pkg::gcnt_t      ovr_grp    [swlss_pkg::NGRP];
	swlss_pkg::smp_t       p95_all;
	swlss_pkg::smp_t       max_all;
	swlss_pkg::cnt_t       ovr_all;

	swlss_pkg::cell_cmd_t  cmd;
	swlss_pkg::cell_op_t   op;
	swlss_pkg::cell_link_t lnk [swlss_pkg::WINDOW_MAX];
	logic [swlss_pkg::WINDOW_MAX-1:0] over;

	swlss_pkg::cnt_t       len_eff;
	swlss_pkg::idx_t       max_idx;
	logic                  full;
	logic                  accept;
	logic                  div_start;
	logic                  div_busy;
	swlss_pkg::smp_t       div_quo;
	logic                  out_load;

	// a written length of zero acts as one, anything past the row size as the row size
	always_comb begin
		if (wl_q == '0) begin
			len_eff = swlss_pkg::cnt_t'(1);
		end else if (wl_q > swlss_pkg::cnt_t'(swlss_pkg::WINDOW_MAX)) begin
			len_eff = swlss_pkg::cnt_t'(swlss_pkg::WINDOW_MAX);
		end else begin
			len_eff = wl_q;
		end
	end

	assign full         = (cnt_q == len_eff);
	assign max_idx      = swlss_pkg::idx_t'(cnt_q - swlss_pkg::cnt_t'(1));
	assign sample_stall = (state_q != swlss_pkg::ST_IDLE);
	assign accept       = sample_valid && !sample_stall;

	assign cmd.op     = op;
	assign cmd.sample = smp_q;
	assign cmd.evict  = rd_q;
	assign cmd.oldest = swlss_pkg::idx_t'(len_eff - swlss_pkg::cnt_t'(1));
	assign cmd.budget = bud_q;

	always_comb begin
		state_d   = state_q;
		op        = swlss_pkg::OP_NONE;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			swlss_pkg::ST_IDLE: begin
				if (cfg_wr && (cfg_idx == swlss_pkg::REG_WINDOW_LENGTH)) begin
					op = swlss_pkg::OP_CLEAR;
				end
				if (sample_valid) begin
					state_d = swlss_pkg::ST_EVICT;
				end
			end
			swlss_pkg::ST_EVICT: begin
				if (full) begin
					op = swlss_pkg::OP_DELETE;
				end
				state_d = swlss_pkg::ST_INSERT;
			end
			swlss_pkg::ST_INSERT: begin
				op        = swlss_pkg::OP_INSERT;
				div_start = 1'b1;
				state_d   = swlss_pkg::ST_GATHER;
			end
			swlss_pkg::ST_GATHER: begin
				state_d = swlss_pkg::ST_WAIT;
			end
			swlss_pkg::ST_WAIT: begin
				if (!div_busy && (!out_vld_q || !result_stall)) begin
					out_load = 1'b1;
					state_d  = swlss_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = swlss_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= swlss_pkg::ST_IDLE;
			wl_q      <= swlss_pkg::cnt_t'(swlss_pkg::WINDOW_MAX);
			bud_q     <= '0;
			cnt_q     <= '0;
			wp_q      <= '0;
			sum_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				unique case (cfg_idx)
					swlss_pkg::REG_WINDOW_LENGTH: begin
						wl_q  <= cfg_wdata[swlss_pkg::LEN_W-1:0];
						cnt_q <= '0;
						wp_q  <= '0;
						sum_q <= '0;
					end
					swlss_pkg::REG_BUDGET: begin
						bud_q <= cfg_wdata;
					end
					default: begin
					end
				endcase
			end
			if (state_q == swlss_pkg::ST_EVICT) begin
				sum_q <= sum_q - swlss_pkg::SUM_W'(full ? rd_q : '0)
					+ swlss_pkg::SUM_W'(smp_q);
				if (!full) begin
					cnt_q <= cnt_q + swlss_pkg::cnt_t'(1);
				end
				if (swlss_pkg::cnt_t'(wp_q) + swlss_pkg::cnt_t'(1) == len_eff) begin
					wp_q <= '0;
				end else begin
					wp_q <= wp_q + swlss_pkg::idx_t'(1);
				end
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (!result_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// ring of samples in arrival order; once the window is full, the slot at the write pointer is the oldest
	always_ff @(posedge clk) begin
		if (accept) begin
			smp_q <= sample_us;
			rd_q  <= ring_q[wp_q];
		end
		if (state_q == swlss_pkg::ST_EVICT) begin
			ring_q[wp_q] <= smp_q;
		end
	end

	for (genvar i = 0; i < swlss_pkg::WINDOW_MAX; i++) begin : g_cell
		swlss_pkg::cell_link_t lft;
		swlss_pkg::cell_link_t rgt;
		if (i == 0) begin : g_first
			assign lft = swlss_pkg::LINK_EDGE;
		end else begin : g_inner_l
			assign lft = lnk[i-1];
		end
		if (i == swlss_pkg::WINDOW_MAX - 1) begin : g_last
			assign rgt = swlss_pkg::LINK_EDGE;
		end else begin : g_inner_r
			assign rgt = lnk[i+1];
		end
		swlss_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.left   (lft),
			.right  (rgt),
			.link   (lnk[i]),
			.over   (over[i])
		);
	end

	swlss_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (cnt_q),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	// first reduction stage: per group of cells, pick by position and count over budget
	always_comb begin
		for (int g = 0; g < swlss_pkg::NGRP; g++) begin
			p95_grp[g] = '0;
			max_grp[g] = '0;
			ovr_grp[g] = '0;
			for (int k = 0; k < swlss_pkg::GRP; k++) begin
				p95_grp[g] = p95_grp[g] | (lnk[g*swlss_pkg::GRP+k].val &
					{swlss_pkg::SMP_W{swlss_pkg::idx_t'(g*swlss_pkg::GRP+k) == rank_q}});
				max_grp[g] = max_grp[g] | (lnk[g*swlss_pkg::GRP+k].val &
					{swlss_pkg::SMP_W{swlss_pkg::idx_t'(g*swlss_pkg::GRP+k) == max_idx}});
				ovr_grp[g] = ovr_grp[g] + swlss_pkg::gcnt_t'(over[g*swlss_pkg::GRP+k]);
			end
		end
	end

	// second stage: fold the groups
	always_comb begin
		p95_all = '0;
		max_all = '0;
		ovr_all = '0;
		for (int g = 0; g < swlss_pkg::NGRP; g++) begin
			p95_all = p95_all | p95_grp_s1[g];
			max_all = max_all | max_grp_s1[g];
			ovr_all = ovr_all + swlss_pkg::cnt_t'(ovr_grp_s1[g]);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == swlss_pkg::ST_INSERT) begin
			rank_q <= swlss_pkg::p95_index(cnt_q);
		end
		if (state_q == swlss_pkg::ST_GATHER) begin
			p95_grp_s1 <= p95_grp;
			max_grp_s1 <= max_grp;
			ovr_grp_s1 <= ovr_grp;
		end
		if (out_load) begin
			cnt_out_q <= cnt_q;
			avg_out_q <= div_quo;
			max_out_q <= max_all;
			p95_out_q <= p95_all;
			ovr_out_q <= ovr_all;
		end
	end

	assign result_valid      = out_vld_q;
	assign sample_count      = cnt_out_q;
	assign average_us        = avg_out_q;
	assign maximum_us        = max_out_q;
	assign p95_us            = p95_out_q;
	assign over_budget_count = ovr_out_q;

	`SWLSS_ASSERT_NEXT(a_busy_after_transfer, sample_valid && !sample_stall, sample_stall)
	`SWLSS_ASSERT_HOLDS(a_count_in_window, out_load, (cnt_q != '0) && (cnt_q <= len_eff))
	`SWLSS_ASSERT_HOLDS(a_over_le_count, result_valid, over_budget_count <= sample_count)
	`SWLSS_ASSERT_HOLDS(a_order_of_stats, result_valid,
		(p95_us <= maximum_us) && (average_us <= maximum_us))

endmodule

@@ dv/tb_sliding_window_latency_stats_unit.sv @@
// testbench of the sliding window latency statistics unit: directed and random samples
module tb_sliding_window_latency_stats_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 60;
	localparam swlss_pkg::smp_t SMP_MAX = {swlss_pkg::SMP_W{1'b1}};

	typedef struct packed {
		swlss_pkg::cnt_t sample_count;
		swlss_pkg::smp_t average_us;
		swlss_pkg::smp_t maximum_us;
		swlss_pkg::smp_t p95_us;
		swlss_pkg::cnt_t over_budget_count;
	} window_stats_t;

	logic clk;
	logic arst_n;
	logic cfg_wr;
	swlss_pkg::cfg_idx_t cfg_idx;
	logic [swlss_pkg::SMP_W-1:0] cfg_wdata;
	logic sample_valid;
	logic sample_stall;
	logic [swlss_pkg::SMP_W-1:0] sample_us;
	logic result_valid;
	logic result_stall;
	logic [swlss_pkg::LEN_W-1:0] sample_count;
	logic [swlss_pkg::SMP_W-1:0] average_us;
	logic [swlss_pkg::SMP_W-1:0] maximum_us;
	logic [swlss_pkg::SMP_W-1:0] p95_us;
	logic [swlss_pkg::LEN_W-1:0] over_budget_count;

	// predictor state
	swlss_pkg::smp_t window_samples[$];
	int window_limit;
	swlss_pkg::smp_t budget_value;
	window_stats_t expected_stats[$];

	int mismatch_count;
	int sender_idle_pct;
	int receiver_idle_pct;
	int quiet_cycles;

	sliding_window_latency_stats_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr(cfg_wr),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample_us(sample_us),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.sample_count(sample_count),
		.average_us(average_us),
		.maximum_us(maximum_us),
		.p95_us(p95_us),
		.over_budget_count(over_budget_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic window_stats_t compute_window_stats();
		swlss_pkg::smp_t ordered[swlss_pkg::WINDOW_MAX];
		swlss_pkg::smp_t v;
		logic [swlss_pkg::SUM_W-1:0] total;
		window_stats_t r;
		int n;
		int i;
		int j;
		int rank;
		n = window_samples.size();
		total = '0;
		r = '0;
		for (i = 0; i < n; i++) begin
			v = window_samples[i];
			total += swlss_pkg::SUM_W'(v);
			if (v > r.maximum_us)
				r.maximum_us = v;
			if (v > budget_value)
				r.over_budget_count++;
			j = i;
			while (j > 0 && ordered[j-1] > v) begin
				ordered[j] = ordered[j-1];
				j--;
			end
			ordered[j] = v;
		end
		// nearest rank ceil(19n/20)
		rank = (19 * n + 19) / 20;
		if (rank < 1)
			rank = 1;
		if (rank > n)
			rank = n;
		r.sample_count = swlss_pkg::cnt_t'(n);
		r.average_us = swlss_pkg::smp_t'(total / swlss_pkg::SUM_W'(n));
		r.p95_us = ordered[rank-1];
		return r;
	endfunction

	task automatic send_sample(input swlss_pkg::smp_t value);
		bit taken;
		while ($urandom_range(99) < sender_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample_us <= value;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !sample_stall;
			@(posedge clk);
		end
		window_samples.insert(window_samples.size(), value);
		while (window_samples.size() > window_limit)
			window_samples.delete(0);
		expected_stats.insert(expected_stats.size(), compute_window_stats());
	endtask

	task automatic drain_results();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (expected_stats.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_register(input swlss_pkg::cfg_idx_t idx,
		input logic [swlss_pkg::SMP_W-1:0] data);
		logic [swlss_pkg::LEN_W-1:0] len_field;
		drain_results();
		cfg_wr <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_wr <= 1'b0;
		@(posedge clk);
		if (idx == swlss_pkg::REG_WINDOW_LENGTH) begin
			len_field = data[swlss_pkg::LEN_W-1:0];
			window_limit = (len_field == 0) ? 1 :
				(len_field > swlss_pkg::WINDOW_MAX) ? swlss_pkg::WINDOW_MAX :
				int'(len_field);
			window_samples.delete();
		end else begin
			budget_value = data;
		end
	endtask

	function automatic swlss_pkg::smp_t pick_sample(input int style);
		int near;
		case (style)
			1: return swlss_pkg::smp_t'($urandom_range(255));
			2: begin
				case ($urandom_range(3))
					0: return '0;
					1: return swlss_pkg::smp_t'(1);
					2: return SMP_MAX - swlss_pkg::smp_t'(1);
					default: return SMP_MAX;
				endcase
			end
			3: begin
				near = int'(budget_value) + int'($urandom_range(4)) - 2;
				if (near < 0)
					near = 0;
				if (near > int'(SMP_MAX))
					near = int'(SMP_MAX);
				return swlss_pkg::smp_t'(near);
			end
			default: return swlss_pkg::smp_t'($urandom());
		endcase
	endfunction

	task automatic check_field(input string field, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			mismatch_count++;
		end
	endtask

	// result side: stall at random and compare each transfer with the oldest expectation
	initial begin
		window_stats_t got;
		window_stats_t want;
		bit fire;
		result_stall <= 1'b0;
		forever begin
			@(negedge clk);
			fire = arst_n && result_valid && !result_stall;
			got = '{sample_count, average_us, maximum_us, p95_us, over_budget_count};
			@(posedge clk);
			if (fire) begin
				if (expected_stats.size() == 0) begin
					$error("result transfer with nothing expected");
					mismatch_count++;
				end else begin
					want = expected_stats[0];
					expected_stats.delete(0);
					check_field("sample_count", 32'(want.sample_count),
						32'(got.sample_count));
					check_field("average_us", 32'(want.average_us), 32'(got.average_us));
					check_field("maximum_us", 32'(want.maximum_us), 32'(got.maximum_us));
					check_field("p95_us", 32'(want.p95_us), 32'(got.p95_us));
					check_field("over_budget_count", 32'(want.over_budget_count),
						32'(got.over_budget_count));
				end
			end
			result_stall <= ($urandom_range(99) < receiver_idle_pct);
		end
	end

	// ends the run when no transfer happens for too long
	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < IDLE_LIMIT) begin
			@(negedge clk);
			if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	task automatic test_reset_state();
		// window 64 and budget 0 from reset, nothing written yet
		send_sample('0);
		send_sample(SMP_MAX);
		send_sample(swlss_pkg::smp_t'(1));
		send_sample(swlss_pkg::smp_t'(24'h800000));
		send_sample(swlss_pkg::smp_t'(24'h7FFFFF));
	endtask

	task automatic test_window_bounds();
		// zero length acts as one
		write_register(swlss_pkg::REG_WINDOW_LENGTH, '0);
		send_sample(SMP_MAX);
		send_sample('0);
		send_sample(swlss_pkg::smp_t'(5));
		// only the low bits of the write count
		write_register(swlss_pkg::REG_WINDOW_LENGTH, 24'hFFFF82);
		send_sample(swlss_pkg::smp_t'(10));
		send_sample(swlss_pkg::smp_t'(20));
		send_sample(swlss_pkg::smp_t'(30));
		// too large acts as the maximum
		write_register(swlss_pkg::REG_WINDOW_LENGTH, 24'd65);
		send_sample(SMP_MAX);
		send_sample(SMP_MAX);
	endtask

	task automatic test_budget_edges();
		write_register(swlss_pkg::REG_BUDGET, SMP_MAX);
		send_sample(SMP_MAX);
		send_sample('0);
		// a budget change keeps the window
		write_register(swlss_pkg::REG_BUDGET, 24'd16);
		send_sample(swlss_pkg::smp_t'(16));
		send_sample(swlss_pkg::smp_t'(17));
		send_sample(swlss_pkg::smp_t'(15));
	endtask

	task automatic test_random_traffic();
		int phase;
		int k;
		int style;
		logic [swlss_pkg::LEN_W-1:0] len_field;
		logic [swlss_pkg::SMP_W-swlss_pkg::LEN_W-1:0] upper;
		swlss_pkg::smp_t budget_pick;
		for (phase = 0; phase < 12; phase++) begin
			case (phase)
				0: len_field = 7'd64;
				1: len_field = 7'd1;
				2: len_field = 7'd0;
				3: len_field = 7'd127;
				4: len_field = 7'd63;
				default: len_field = 7'($urandom_range(127));
			endcase
			upper = (phase % 2 == 1) ?
				(swlss_pkg::SMP_W-swlss_pkg::LEN_W)'($urandom()) : '0;
			write_register(swlss_pkg::REG_WINDOW_LENGTH, {upper, len_field});
			case (phase % 4)
				0: budget_pick = '0;
				1: budget_pick = SMP_MAX;
				2: budget_pick = swlss_pkg::smp_t'($urandom());
				default: budget_pick = swlss_pkg::smp_t'($urandom_range(300));
			endcase
			write_register(swlss_pkg::REG_BUDGET, budget_pick);
			style = (phase + 1) % 4;
			// one long stretch without any idling on either side
			sender_idle_pct = (phase == 5) ? 0 : 13;
			receiver_idle_pct = (phase == 5) ? 0 : 13;
			for (k = 0; k < 150; k++) begin
				send_sample(pick_sample(($urandom_range(7) == 0) ? 0 : style));
				// hold the sender until every result is back
				if (phase % 3 == 0 && k == 75)
					drain_results();
			end
		end
		sender_idle_pct = 13;
		receiver_idle_pct = 13;
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_wr <= 1'b0;
		cfg_idx <= swlss_pkg::REG_WINDOW_LENGTH;
		cfg_wdata <= '0;
		sample_valid <= 1'b0;
		sample_us <= '0;
		mismatch_count = 0;
		sender_idle_pct = 13;
		receiver_idle_pct = 13;
		window_limit = swlss_pkg::WINDOW_MAX;
		budget_value = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_window_bounds();
		test_budget_edges();
		test_random_traffic();

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_stats.size() != 0) begin
			$error("%0d expected results never arrived", expected_stats.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/swlss_pkg.sv
hdl/swlss_cell.sv
hdl/swlss_div.sv
hdl/sliding_window_latency_stats_unit.sv
dv/tb_sliding_window_latency_stats_unit.sv
